[src/near_mv_candidate_search_core_macros.svh]
// Assertion macros shared by the near motion vector candidate search RTL.
`ifndef NEAR_MV_CANDIDATE_SEARCH_CORE_MACROS_SVH
`define NEAR_MV_CANDIDATE_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define NMVCS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define NMVCS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/nmvcs_pkg.sv]
// Types, constants and helper functions for the near motion vector candidate search.
package nmvcs_pkg;

  localparam int MV_W    = 16;
  localparam int INFO_W  = 3;
  localparam int REF_W   = 2;
  localparam int POS_W   = 8;
  localparam int BIAS_W  = 4;
  localparam int PROB_W  = 8;
  localparam int CNT_W   = 3;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int MB_SHIFT = 7;
  localparam int CNT_SAT = 5;

  localparam logic [1:0] REG_SIGN_BIAS = 2'd0;
  localparam logic [1:0] REG_MB_COLS   = 2'd1;
  localparam logic [1:0] REG_MB_ROWS   = 2'd2;

  typedef logic [MV_W-1:0] mv_comp_t;

  typedef struct packed {
    mv_comp_t x;
    mv_comp_t y;
  } vec_t;

  typedef struct packed {
    logic [REF_W-1:0]  current_ref;
    logic [INFO_W-1:0] above_info;
    vec_t              above_vec;
    logic [INFO_W-1:0] left_info;
    vec_t              left_mv;
    logic [INFO_W-1:0] corner_info;
    vec_t              corner_mv;
    logic [POS_W-1:0]  mb_col;
    logic [POS_W-1:0]  mb_row;
  } ctx_t;

  typedef struct packed {
    vec_t              best;
    vec_t              nearest;
    vec_t              near;
    logic [PROB_W-1:0] prob_zero;
    logic [PROB_W-1:0] prob_nearest;
    logic [PROB_W-1:0] prob_near;
    logic [PROB_W-1:0] prob_split;
  } cand_t;

  localparam logic [PROB_W-1:0] PROB_TAB [CNT_SAT+1][4] = '{
    '{8'd7,   8'd1,   8'd1,   8'd143},
    '{8'd14,  8'd18,  8'd14,  8'd107},
    '{8'd135, 8'd64,  8'd57,  8'd68},
    '{8'd60,  8'd56,  8'd128, 8'd65},
    '{8'd159, 8'd134, 8'd128, 8'd34},
    '{8'd234, 8'd188, 8'd128, 8'd28}
  };

  // When the bounds cross, a value above hi gets hi and any other value gets lo.
  function automatic mv_comp_t clamp_comp(input mv_comp_t v,
                                          input logic signed [MV_W:0] lo,
                                          input logic signed [MV_W:0] hi);
    logic signed [MV_W:0] v_ext;
    logic signed [MV_W:0] r;
    v_ext = $signed({v[MV_W-1], v});
    r = (v_ext < lo) ? lo : v_ext;
    if (v_ext > hi) begin
      r = hi;
    end
    return r[MV_W-1:0];
  endfunction

  function automatic logic [PROB_W-1:0] prob_lookup(input logic [CNT_W-1:0] cnt,
                                                    input logic [1:0] col);
    logic [CNT_W-1:0] c;
    c = (cnt > CNT_W'(CNT_SAT)) ? CNT_W'(CNT_SAT) : cnt;
    return PROB_TAB[c][col];
  endfunction

endpackage

[src/nmvcs_ifs.sv]
// Valid/ready channel interfaces for macroblock contexts and candidate results.
interface nmvcs_ctx_if;
  import nmvcs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REF_W-1:0]         current_ref;
  logic [INFO_W-1:0]        above_info;
  logic signed [MV_W-1:0]   above_mv_x;
  logic signed [MV_W-1:0]   above_mv_y;
  logic [INFO_W-1:0]        left_info;
  logic signed [MV_W-1:0]   left_mv_x;
  logic signed [MV_W-1:0]   left_mv_y;
  logic [INFO_W-1:0]        corner_info;
  logic signed [MV_W-1:0]   corner_mv_x;
  logic signed [MV_W-1:0]   corner_mv_y;
  logic [POS_W-1:0]         mb_col;
  logic [POS_W-1:0]         mb_row;

  modport source (output valid, current_ref, above_info, above_mv_x, above_mv_y,
                  left_info, left_mv_x, left_mv_y, corner_info, corner_mv_x,
                  corner_mv_y, mb_col, mb_row, input ready);
  modport sink (input valid, current_ref, above_info, above_mv_x, above_mv_y,
                left_info, left_mv_x, left_mv_y, corner_info, corner_mv_x,
                corner_mv_y, mb_col, mb_row, output ready);
endinterface

interface nmvcs_cand_if;
  import nmvcs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MV_W-1:0]   best_x;
  logic signed [MV_W-1:0]   best_y;
  logic signed [MV_W-1:0]   nearest_x;
  logic signed [MV_W-1:0]   nearest_y;
  logic signed [MV_W-1:0]   near_x;
  logic signed [MV_W-1:0]   near_y;
  logic [PROB_W-1:0]        prob_zero;
  logic [PROB_W-1:0]        prob_nearest;
  logic [PROB_W-1:0]        prob_near;
  logic [PROB_W-1:0]        prob_split;

  modport source (output valid, best_x, best_y, nearest_x, nearest_y, near_x, near_y,
                  prob_zero, prob_nearest, prob_near, prob_split, input ready);
  modport sink (input valid, best_x, best_y, nearest_x, nearest_y, near_x, near_y,
                prob_zero, prob_nearest, prob_near, prob_split, output ready);
endinterface

[src/near_mv_candidate_search_core.sv]
// Top level of the near motion vector candidate search: APB registers and a two-register pipeline.
// One macroblock context enters per transaction and yields exactly one candidate transaction:
// best, nearest and near vectors clamped to a one-macroblock border, plus the four mode-tree
// probabilities. The block sustains one transaction per clock cycle while cand.ready stays high;
// a result passes from the context register to the result register, with only combinational
// logic between them. The context register accepts a new transaction while a finished result waits
// at the output, if the context register is empty. Registers sign_bias_bits, frame_mb_cols and
// frame_mb_rows sit at byte addresses 0, 4 and 8 and should only be written while idle.
`include "near_mv_candidate_search_core_macros.svh"

module near_mv_candidate_search_core (
  input  logic                            clk,
  input  logic                            rst,
  nmvcs_ctx_if.sink                       ctx,
  nmvcs_cand_if.source                    cand,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nmvcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [nmvcs_pkg::PDATA_W-1:0]   pwdata,
  output logic [nmvcs_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import nmvcs_pkg::*;

  logic [BIAS_W-1:0] sign_bias_bits;
  logic [POS_W-1:0]  frame_mb_cols;
  logic [POS_W-1:0]  frame_mb_rows;

  logic  s1_valid;
  ctx_t  s1;
  logic  o_valid;
  cand_t o_res;
  logic  adv;
  ctx_t  ctx_in;
  cand_t res_next;

  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_bias_bits <= '0;
      frame_mb_cols  <= POS_W'(1);
      frame_mb_rows  <= POS_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIGN_BIAS: sign_bias_bits <= pwdata[BIAS_W-1:0];
        REG_MB_COLS:   frame_mb_cols  <= pwdata[POS_W-1:0];
        REG_MB_ROWS:   frame_mb_rows  <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIGN_BIAS: prdata = PDATA_W'(sign_bias_bits);
      REG_MB_COLS:   prdata = PDATA_W'(frame_mb_cols);
      REG_MB_ROWS:   prdata = PDATA_W'(frame_mb_rows);
      default:       prdata = '0;
    endcase
  end

  // Pipeline handshake.
  assign adv       = !o_valid || cand.ready;
  assign ctx.ready = !s1_valid || adv;

  always_comb begin
    ctx_in.current_ref = ctx.current_ref;
    ctx_in.above_info  = ctx.above_info;
    ctx_in.above_vec   = '{x: ctx.above_mv_x, y: ctx.above_mv_y};
    ctx_in.left_info   = ctx.left_info;
    ctx_in.left_mv     = '{x: ctx.left_mv_x, y: ctx.left_mv_y};
    ctx_in.corner_info = ctx.corner_info;
    ctx_in.corner_mv   = '{x: ctx.corner_mv_x, y: ctx.corner_mv_y};
    ctx_in.mb_col      = ctx.mb_col;
    ctx_in.mb_row      = ctx.mb_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctx.ready) begin
      s1_valid <= ctx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctx.ready && ctx.valid) begin
      s1 <= ctx_in;
    end
  end

  // Candidate merge, swap, best choice, clamp and probability lookup.
  logic [INFO_W-1:0]       nb_info [3];
  vec_t                    nb_mv   [3];
  logic [CNT_W-1:0]        nb_w    [3];
  vec_t                    mv      [4];
  logic [CNT_W-1:0]        cnt     [4];
  logic [1:0]              idx;
  vec_t                    v;
  logic                    flip;
  vec_t                    tmp_mv;
  logic [CNT_W-1:0]        tmp_cnt;
  vec_t                    best;
  logic [POS_W:0]          col_p1;
  logic [POS_W:0]          row_p1;
  logic signed [POS_W:0]   col_d;
  logic signed [POS_W:0]   row_d;
  logic signed [MV_W:0]    lft;
  logic signed [MV_W:0]    rgt;
  logic signed [MV_W:0]    top;
  logic signed [MV_W:0]    bot;

  always_comb begin
    nb_info = '{s1.above_info, s1.left_info, s1.corner_info};
    nb_mv   = '{s1.above_vec, s1.left_mv, s1.corner_mv};
    nb_w    = '{CNT_W'(2), CNT_W'(2), CNT_W'(1)};
    for (int i = 0; i < 4; i++) begin
      mv[i]  = '0;
      cnt[i] = '0;
    end
    idx = '0;
    for (int n = 0; n < 3; n++) begin
      flip = sign_bias_bits[nb_info[n][1:0]] ^ sign_bias_bits[s1.current_ref];
      v.x  = flip ? MV_W'(MV_W'(0) - nb_mv[n].x) : nb_mv[n].x;
      v.y  = flip ? MV_W'(MV_W'(0) - nb_mv[n].y) : nb_mv[n].y;
      if (nb_info[n][1:0] != '0) begin
        if ((nb_mv[n].x | nb_mv[n].y) != '0) begin
          if (n == 0 || v != mv[idx]) begin
            idx     = idx + 2'd1;
            mv[idx] = v;
          end
          cnt[idx] = cnt[idx] + nb_w[n];
        end else begin
          cnt[0] = cnt[0] + nb_w[n];
        end
      end
    end

    if (cnt[3] != '0 && mv[3] == mv[1]) begin
      cnt[1] = cnt[1] + CNT_W'(1);
    end

    cnt[3] = CNT_W'((CNT_W'(s1.above_info[2]) + CNT_W'(s1.left_info[2])) << 1)
             + CNT_W'(s1.corner_info[2]);

    if (cnt[2] > cnt[1]) begin
      tmp_cnt = cnt[1];
      tmp_mv  = mv[1];
      cnt[1]  = cnt[2];
      mv[1]   = mv[2];
      cnt[2]  = tmp_cnt;
      mv[2]   = tmp_mv;
    end else begin
      tmp_cnt = '0;
      tmp_mv  = '0;
    end
    best = (cnt[1] >= cnt[0]) ? mv[1] : mv[0];

    col_p1 = {1'b0, s1.mb_col} + (POS_W+1)'(1);
    row_p1 = {1'b0, s1.mb_row} + (POS_W+1)'(1);
    col_d  = $signed({1'b0, frame_mb_cols}) - $signed({1'b0, s1.mb_col});
    row_d  = $signed({1'b0, frame_mb_rows}) - $signed({1'b0, s1.mb_row});
    lft    = -$signed({1'b0, col_p1, MB_SHIFT'(0)});
    top    = -$signed({1'b0, row_p1, MB_SHIFT'(0)});
    rgt    = $signed({col_d[POS_W], col_d, MB_SHIFT'(0)});
    bot    = $signed({row_d[POS_W], row_d, MB_SHIFT'(0)});

    res_next.best.x       = clamp_comp(best.x, lft, rgt);
    res_next.best.y       = clamp_comp(best.y, top, bot);
    res_next.nearest.x    = clamp_comp(mv[1].x, lft, rgt);
    res_next.nearest.y    = clamp_comp(mv[1].y, top, bot);
    res_next.near.x       = clamp_comp(mv[2].x, lft, rgt);
    res_next.near.y       = clamp_comp(mv[2].y, top, bot);
    res_next.prob_zero    = prob_lookup(cnt[0], 2'd0);
    res_next.prob_nearest = prob_lookup(cnt[1], 2'd1);
    res_next.prob_near    = prob_lookup(cnt[2], 2'd2);
    res_next.prob_split   = prob_lookup(cnt[3], 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      o_res <= res_next;
    end
  end

  assign cand.valid        = o_valid;
  assign cand.best_x       = o_res.best.x;
  assign cand.best_y       = o_res.best.y;
  assign cand.nearest_x    = o_res.nearest.x;
  assign cand.nearest_y    = o_res.nearest.y;
  assign cand.near_x       = o_res.near.x;
  assign cand.near_y       = o_res.near.y;
  assign cand.prob_zero    = o_res.prob_zero;
  assign cand.prob_nearest = o_res.prob_nearest;
  assign cand.prob_near    = o_res.prob_near;
  assign cand.prob_split   = o_res.prob_split;

  `NMVCS_ASSERT_NXT(a_ctx_to_s1, ctx.valid && ctx.ready, s1_valid, "accepted context lost")
  `NMVCS_ASSERT_NXT(a_s1_to_out, s1_valid && adv, o_valid, "context advanced with no result")
  `NMVCS_ASSERT_IMP(a_ready_full, !ctx.ready, s1_valid && o_valid && !cand.ready, "stall with room")
  `NMVCS_ASSERT_IMP(a_swap_order, s1_valid, cnt[2] <= cnt[1], "near weight above nearest weight")

endmodule
